@@ rtl/core/jan_pkg.sv @@
`default_nettype none

package jan_pkg;

  localparam int unsigned RAW_W        = 12;
  localparam int unsigned SCALE_SHIFT  = 4;
  localparam int unsigned CAL_W        = 16;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned FRAC_BITS    = 14;
  localparam int unsigned STEP_PER_STG = 2;
  localparam int unsigned DIV_STAGES   = FRAC_BITS / STEP_PER_STG;
  localparam int unsigned PIPE_DEPTH   = DIV_STAGES + 2;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [POS_W-1:0] Q_ONE = POS_W'(1) << FRAC_BITS;

  localparam logic [CAL_W-1:0] RST_CENTER    = 16'd32760;
  localparam logic [CAL_W-1:0] RST_LO        = 16'd0;
  localparam logic [CAL_W-1:0] RST_HI        = 16'd65520;
  localparam logic [CAL_W-1:0] RST_DEAD_BAND = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_MIN_X     = 3'd1,
    CFG_MAX_X     = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_MIN_Y     = 3'd4,
    CFG_MAX_Y     = 3'd5,
    CFG_DEAD_BAND = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             button_level;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
    logic                    pressed;
  } out_item_t;

  typedef struct packed {
    logic [CAL_W-1:0] center;
    logic [CAL_W-1:0] lo;
    logic [CAL_W-1:0] hi;
  } axis_cal_t;

  typedef struct packed {
    axis_cal_t        x;
    axis_cal_t        y;
    logic [CAL_W-1:0] dead_band;
  } cal_t;

  typedef struct packed {
    logic [CAL_W-1:0]     rem;
    logic [CAL_W-1:0]     divisor;
    logic [FRAC_BITS-1:0] quot;
    logic                 sat;
    logic                 zero;
    logic                 neg;
  } div_t;

endpackage

`default_nettype wire

@@ rtl/core/joystick_axis_normalizer.sv @@
// Joystick axis normaliser.
// Input channel in_valid/in_stall/in_data carries one item: a 12-bit X and
// Y sample and the active-low button level. Output channel
// out_valid/out_stall/out_data returns one item per input: X and Y in signed
// Q1.14 (16384 is full scale) with deadzone and saturation applied, and the
// pressed flag. Calibration registers are written over cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high.
// The datapath is nine register stages: classification and range select,
// seven stages of a restoring divider retiring two quotient bits each, and
// the output register. A result passes through them in that order; one item
// per cycle is accepted and delivered when the output is not stalled.
// Each stage advances when it is empty or the stage after it moves, so
// bubbles close up and in_stall rises only when every stage holds an item
// and out_stall is high.
// Synchronous reset empties the pipeline and loads the default calibration.
`default_nettype none

module joystick_axis_normalizer
  import jan_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_data
);

  cal_t                  cal;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] vld_in;
  logic [PIPE_DEPTH-1:0] adv;
  logic [PIPE_DEPTH-2:0] btn;
  logic [PIPE_DEPTH-2:0] btn_in;
  div_t                  dx [DIV_STAGES+1];
  div_t                  dy [DIV_STAGES+1];
  out_item_t             res;
  out_item_t             res_reg;

  jan_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  always_comb begin
    adv[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || !out_stall;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];
  assign vld_in   = {vld[PIPE_DEPTH-2:0], in_valid};
  assign btn_in   = {btn[PIPE_DEPTH-3:0], !in_data.button_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PIPE_DEPTH - 1; i++) begin
      if (adv[i]) begin
        btn[i] <= btn_in[i];
      end
    end
  end

  jan_axis_prep u_prep_x (
    .clk       (clk),
    .en        (adv[0]),
    .raw       (in_data.raw_x),
    .cal       (cal.x),
    .dead_band (cal.dead_band),
    .q         (dx[0])
  );

  jan_axis_prep u_prep_y (
    .clk       (clk),
    .en        (adv[0]),
    .raw       (in_data.raw_y),
    .cal       (cal.y),
    .dead_band (cal.dead_band),
    .q         (dy[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    jan_div_step u_div_x (
      .clk (clk),
      .en  (adv[s+1]),
      .d   (dx[s]),
      .q   (dx[s+1])
    );
    jan_div_step u_div_y (
      .clk (clk),
      .en  (adv[s+1]),
      .d   (dy[s]),
      .q   (dy[s+1])
    );
  end

  function automatic logic [POS_W-1:0] finish(input div_t d);
    logic [POS_W-1:0] mag;
    mag = d.zero ? '0 : (d.sat ? Q_ONE : POS_W'(d.quot));
    return d.neg ? POS_W'(0) - mag : mag;
  endfunction

  always_comb begin
    res.x_position = $signed(finish(dx[DIV_STAGES]));
    res.y_position = $signed(finish(dy[DIV_STAGES]));
    res.pressed    = btn[PIPE_DEPTH-2];
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_DEPTH-1]) begin
      res_reg <= res;
    end
  end

  assign out_valid = vld[PIPE_DEPTH-1];
  assign out_data  = res_reg;

  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.x_position <= $signed(Q_ONE)
                   && out_data.x_position >= -$signed(Q_ONE)))
    else $error("x_position beyond full scale");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.y_position <= $signed(Q_ONE)
                   && out_data.y_position >= -$signed(Q_ONE)))
    else $error("y_position beyond full scale");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ rtl/core/jan_cfg_regs.sv @@
`default_nettype none

module jan_cfg_regs
  import jan_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_data,
  output cal_t                      cal
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.x.center  <= RST_CENTER;
      cal.x.lo      <= RST_LO;
      cal.x.hi      <= RST_HI;
      cal.y.center  <= RST_CENTER;
      cal.y.lo      <= RST_LO;
      cal.y.hi      <= RST_HI;
      cal.dead_band <= RST_DEAD_BAND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:  cal.x.center  <= cfg_data;
        CFG_MIN_X:     cal.x.lo      <= cfg_data;
        CFG_MAX_X:     cal.x.hi      <= cfg_data;
        CFG_CENTER_Y:  cal.y.center  <= cfg_data;
        CFG_MIN_Y:     cal.y.lo      <= cfg_data;
        CFG_MAX_Y:     cal.y.hi      <= cfg_data;
        CFG_DEAD_BAND: cal.dead_band <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jan_axis_prep.sv @@
`default_nettype none

module jan_axis_prep
  import jan_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [RAW_W-1:0] raw,
  input  axis_cal_t             cal,
  input  wire logic [CAL_W-1:0] dead_band,
  output div_t                  q
);

  localparam int unsigned EXT_W = CAL_W + 2;

  logic [EXT_W-1:0] rel;
  logic [EXT_W-1:0] db_pos;
  logic [EXT_W-1:0] db_neg;
  logic [EXT_W-1:0] rng_p;
  logic [EXT_W-1:0] rng_n;
  logic [EXT_W-1:0] rng;
  logic [EXT_W-1:0] rel_abs;
  logic             is_pos;
  logic             is_neg;
  logic             rng_ok;
  div_t             d;

  always_comb begin
    rel     = {2'b00, raw, {SCALE_SHIFT{1'b0}}} - {2'b00, cal.center};
    db_pos  = {2'b00, dead_band};
    db_neg  = EXT_W'(0) - db_pos;
    is_pos  = $signed(rel) > $signed(db_pos);
    is_neg  = $signed(rel) < $signed(db_neg);
    rng_p   = {2'b00, cal.hi} - {2'b00, cal.center};
    rng_n   = {2'b00, cal.center} - {2'b00, cal.lo};
    rng     = is_pos ? rng_p : rng_n;
    rel_abs = is_pos ? rel : EXT_W'(0) - rel;
    rng_ok  = !rng[EXT_W-1] && (rng != '0);

    d.rem     = rel_abs[CAL_W-1:0];
    d.divisor = rng[CAL_W-1:0];
    d.quot    = '0;
    d.sat     = rel_abs[CAL_W-1:0] >= rng[CAL_W-1:0];
    d.zero    = !(is_pos || is_neg) || !rng_ok;
    d.neg     = is_neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jan_div_step.sv @@
`default_nettype none

module jan_div_step
  import jan_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  div_t      d,
  output div_t      q
);

  div_t           nxt;
  logic [CAL_W:0] trial;

  always_comb begin
    nxt   = d;
    trial = '0;
    for (int i = 0; i < STEP_PER_STG; i++) begin
      trial = {nxt.rem, 1'b0};
      if (trial >= {1'b0, nxt.divisor}) begin
        trial    = trial - {1'b0, nxt.divisor};
        nxt.quot = {nxt.quot[FRAC_BITS-2:0], 1'b1};
      end else begin
        nxt.quot = {nxt.quot[FRAC_BITS-2:0], 1'b0};
      end
      nxt.rem = trial[CAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ bench/joystick_result_checker.sv @@
`default_nettype none

module joystick_result_checker
  import jan_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  in_item_t                  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        waiting
);

  localparam longint FULL_SCALE = 16384;

  cal_t      cal;
  out_item_t expected_positions[$];
  int        mismatches = 0;

  function automatic logic [POS_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                  input axis_cal_t c,
                                                  input logic [CAL_W-1:0] band);
    longint sample, ctr, lo, hi, db, offset, span, mag, q;
    sample = longint'({raw, 4'b0000});
    ctr    = longint'(c.center);
    lo     = longint'(c.lo);
    hi     = longint'(c.hi);
    db     = longint'(band);
    offset = sample - ctr;
    if (offset > db) begin
      span = hi - ctr;
      mag  = offset;
    end else if (offset < -db) begin
      span = ctr - lo;
      mag  = -offset;
    end else begin
      return '0;
    end
    if (span <= 0) return '0;
    q = (mag * FULL_SCALE) / span;
    if (q > FULL_SCALE) q = FULL_SCALE;
    if (offset < 0) q = -q;
    return q[POS_W-1:0];
  endfunction

  function automatic out_item_t normalise(input in_item_t item);
    out_item_t r;
    r.x_position = scale_axis(item.raw_x, cal.x, cal.dead_band);
    r.y_position = scale_axis(item.raw_y, cal.y, cal.dead_band);
    r.pressed    = (item.button_level == 1'b0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cal.x.center  = RST_CENTER;
      cal.x.lo      = RST_LO;
      cal.x.hi      = RST_HI;
      cal.y.center  = RST_CENTER;
      cal.y.lo      = RST_LO;
      cal.y.hi      = RST_HI;
      cal.dead_band = RST_DEAD_BAND;
      expected_positions.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected item: x_position %0d y_position %0d pressed %0b",
                 out_data.x_position, out_data.y_position, out_data.pressed);
          mismatches++;
        end else begin
          want = expected_positions.pop_front();
          if (out_data.x_position !== want.x_position) begin
            $error("x_position expected %0d got %0d", want.x_position, out_data.x_position);
            mismatches++;
          end
          if (out_data.y_position !== want.y_position) begin
            $error("y_position expected %0d got %0d", want.y_position, out_data.y_position);
            mismatches++;
          end
          if (out_data.pressed !== want.pressed) begin
            $error("pressed expected %0b got %0b", want.pressed, out_data.pressed);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) expected_positions.push_back(normalise(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X:  cal.x.center  = cfg_data;
          CFG_MIN_X:     cal.x.lo      = cfg_data;
          CFG_MAX_X:     cal.x.hi      = cfg_data;
          CFG_CENTER_Y:  cal.y.center  = cfg_data;
          CFG_MIN_Y:     cal.y.lo      = cfg_data;
          CFG_MAX_Y:     cal.y.hi      = cfg_data;
          CFG_DEAD_BAND: cal.dead_band = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    waiting    <= expected_positions.size();
  end

endmodule

`default_nettype wire

@@ bench/tb_joystick_axis_normalizer.sv @@
`default_nettype none

module tb_joystick_axis_normalizer;
  import jan_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int SETTLE = PIPE_DEPTH + 4;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_data  = '0;
  int                   fail_count;
  int                   waiting;

  cal_t cal_now;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  logic [RAW_W-1:0] probe_x [12] = '{0, 4095, 0, 4095, 2047, 2048, 2141, 2142, 1953, 1954,
                                     4095, 0};
  logic [RAW_W-1:0] probe_y [12] = '{0, 4095, 4095, 0, 2047, 2048, 1953, 1954, 2141, 2142,
                                     2047, 2047};

  joystick_axis_normalizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  joystick_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: stretches of no stall, light, heavy and periodic stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  task automatic send_item(input in_item_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic settle();
    hold_off(1);
    while (waiting != 0) @(negedge clk);
    hold_off(SETTLE);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_calibration(input cal_t c);
    cal_now = c;
    write_reg(CFG_CENTER_X,  c.x.center);
    write_reg(CFG_MIN_X,     c.x.lo);
    write_reg(CFG_MAX_X,     c.x.hi);
    write_reg(CFG_CENTER_Y,  c.y.center);
    write_reg(CFG_MIN_Y,     c.y.lo);
    write_reg(CFG_MAX_Y,     c.y.hi);
    write_reg(CFG_DEAD_BAND, c.dead_band);
    write_reg(CFG_SPARE,     16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic axis_cal_t plausible_axis();
    axis_cal_t a;
    a.lo     = CAL_W'($urandom_range(0, 20000));
    a.center = CAL_W'($urandom_range(24000, 40000));
    a.hi     = CAL_W'($urandom_range(44000, 65520));
    return a;
  endfunction

  // bias towards the deadzone edges and the ends of travel
  function automatic logic [RAW_W-1:0] pick_raw(input logic [CAL_W-1:0] centre);
    int base, reach, level;
    base = int'(centre >> 4);
    case ($urandom_range(0, 3))
      0: level = $urandom_range(0, 1) * 4095;
      1: begin
        reach = int'(cal_now.dead_band >> 4) + $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) level = base + reach;
        else level = base - reach;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
      end
      default: level = $urandom_range(0, 4095);
    endcase
    return level[RAW_W-1:0];
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    item.raw_x        = pick_raw(cal_now.x.center);
    item.raw_y        = pick_raw(cal_now.y.center);
    item.button_level = 1'($urandom_range(0, 1));
    return item;
  endfunction

  task automatic run_items(input int count);
    repeat (count) begin
      if (burst_left == 0) begin
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end
      send_item(random_item());
      burst_left--;
    end
  endtask

  initial begin
    cal_t c;
    cal_now.x.center  = RST_CENTER;
    cal_now.x.lo      = RST_LO;
    cal_now.x.hi      = RST_HI;
    cal_now.y         = cal_now.x;
    cal_now.dead_band = RST_DEAD_BAND;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 12; i++) send_item({probe_x[i], probe_y[i], i[0]});

    for (int phase = 0; phase < 12; phase++) begin
      settle();
      case (phase)
        0: c = cal_now;
        1: c = '{x: '{16'd0, 16'd0, 16'd0}, y: '{16'hFFFF, 16'hFFFF, 16'hFFFF},
                 dead_band: 16'd0};
        2: c = '{x: '{16'd0, 16'd0, 16'hFFFF}, y: '{16'hFFFF, 16'd0, 16'hFFFF},
                 dead_band: 16'd0};
        3: c = '{x: '{16'd32768, 16'd0, 16'hFFFF}, y: '{16'd32768, 16'd0, 16'hFFFF},
                 dead_band: 16'd1600};
        4: c = '{x: '{16'd32760, 16'd40000, 16'd20000}, y: '{16'd1000, 16'd2000, 16'd500},
                 dead_band: 16'd100};
        5: c = '{x: '{16'd32768, 16'd32767, 16'd32769}, y: '{16'd16, 16'd0, 16'd32},
                 dead_band: 16'd0};
        6: c = '{x: plausible_axis(), y: plausible_axis(), dead_band: 16'hFFFF};
        9, 10: c = cal_t'({$urandom, $urandom, $urandom});
        default: begin
          c.x         = plausible_axis();
          c.y         = plausible_axis();
          c.dead_band = CAL_W'($urandom_range(0, 4000));
        end
      endcase
      load_calibration(c);
      send_item({12'd0, 12'd4095, 1'b0});
      send_item({12'd4095, 12'd0, 1'b1});
      run_items(85);
    end

    settle();
    if (fail_count == 0 && waiting == 0) begin
      $display("tb_joystick_axis_normalizer passed");
    end else begin
      $display("tb_joystick_axis_normalizer failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("tb_joystick_axis_normalizer failed");
    $finish;
  end

endmodule

`default_nettype wire
